>>> hw/rtl/wsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the wavetable sample generator
// Field widths, register indexes, mode codes and the structs passed between
// the sequencer, the multiply-accumulate unit and the top level.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int MAX_FRAMES          = 256;
  localparam int MAX_HARMONICS       = 64;
  localparam int SINE_TABLE_BITS_DEF = 12;

  localparam int HARM_W     = $clog2(MAX_HARMONICS);
  localparam int FRAME_W    = 8;
  localparam int SAMPLE_W   = 12;
  localparam int COUNT_W    = 9;
  localparam int LOG2_W     = 4;
  localparam int MODE_W     = 2;
  localparam int OUT_W      = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [MODE_W-1:0] MODE_SAW    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2   = 2'd2;

  localparam logic [LOG2_W-1:0] LOG2_MIN = 4'd4;
  localparam logic [LOG2_W-1:0] LOG2_MAX = 4'd12;

  localparam logic signed [OUT_W-1:0] ONE_Q16 = 19'sd65536;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              neg;
    logic [HARM_W-1:0] h_idx;
  } issue_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] value;
  } result_t;

endpackage

>>> hw/rtl/wsg_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_sine_rom: quarter-wave sine table
// Q16 magnitudes of sin over the first quadrant, one entry past the end so
// the mirrored quadrant reaches the peak. Registered read.
// ----------------------------------------------------------------------------
module wsg_sine_rom #(
  parameter int SINE_TABLE_BITS = wsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-2:0] addr,
  output logic [16:0]                data
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [16:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_table();
    qtab_t             tab;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       mag;
    logic signed [63:0] sum;
    for (int r = 0; r <= QUARTER; r++) begin
      x   = (64'(r) * HALF_PI_Q30) / QUARTER;
      x2  = (x * x) >> 30;
      mag = x;
      sum = $signed(x);
      mag = ((mag * x2) >> 30) / 64'd6;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd20;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd42;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd72;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd110;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd156;
      sum = sum + $signed(mag);
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 64'sd8192) >>> 14;
      if (sum > 64'sd65536) begin
        sum = 64'sd65536;
      end
      tab[r] = 17'(sum);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_table();

  always_ff @(posedge clk) begin
    data <= QTAB[addr];
  end

endmodule

>>> hw/rtl/wsg_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_mac: harmonic multiply-accumulate unit
// Scales each table sample by 1/h, accumulates signed terms in Q32, then
// rounds to Q16 and saturates to the output range on the last term.
// ----------------------------------------------------------------------------
module wsg_mac (
  input  logic             clk,
  input  logic             rst,
  input  wsg_pkg::issue_t  iss,
  input  logic [16:0]      rom_data,
  output wsg_pkg::result_t res
);

  localparam int ACC_W = 40;
  localparam int Q_W   = ACC_W - 16;

  function automatic logic [16:0] recip(input logic [wsg_pkg::HARM_W-1:0] idx);
    logic [16:0] v;
    case (idx)
      6'd0:  v = 17'd65536;
      6'd1:  v = 17'd32768;
      6'd2:  v = 17'd21845;
      6'd3:  v = 17'd16384;
      6'd4:  v = 17'd13107;
      6'd5:  v = 17'd10923;
      6'd6:  v = 17'd9362;
      6'd7:  v = 17'd8192;
      6'd8:  v = 17'd7282;
      6'd9:  v = 17'd6554;
      6'd10: v = 17'd5958;
      6'd11: v = 17'd5461;
      6'd12: v = 17'd5041;
      6'd13: v = 17'd4681;
      6'd14: v = 17'd4369;
      6'd15: v = 17'd4096;
      6'd16: v = 17'd3855;
      6'd17: v = 17'd3641;
      6'd18: v = 17'd3449;
      6'd19: v = 17'd3277;
      6'd20: v = 17'd3121;
      6'd21: v = 17'd2979;
      6'd22: v = 17'd2849;
      6'd23: v = 17'd2731;
      6'd24: v = 17'd2621;
      6'd25: v = 17'd2521;
      6'd26: v = 17'd2427;
      6'd27: v = 17'd2341;
      6'd28: v = 17'd2260;
      6'd29: v = 17'd2185;
      6'd30: v = 17'd2114;
      6'd31: v = 17'd2048;
      6'd32: v = 17'd1986;
      6'd33: v = 17'd1928;
      6'd34: v = 17'd1872;
      6'd35: v = 17'd1820;
      6'd36: v = 17'd1771;
      6'd37: v = 17'd1725;
      6'd38: v = 17'd1680;
      6'd39: v = 17'd1638;
      6'd40: v = 17'd1598;
      6'd41: v = 17'd1560;
      6'd42: v = 17'd1524;
      6'd43: v = 17'd1489;
      6'd44: v = 17'd1456;
      6'd45: v = 17'd1425;
      6'd46: v = 17'd1394;
      6'd47: v = 17'd1365;
      6'd48: v = 17'd1337;
      6'd49: v = 17'd1311;
      6'd50: v = 17'd1285;
      6'd51: v = 17'd1260;
      6'd52: v = 17'd1237;
      6'd53: v = 17'd1214;
      6'd54: v = 17'd1192;
      6'd55: v = 17'd1170;
      6'd56: v = 17'd1150;
      6'd57: v = 17'd1130;
      6'd58: v = 17'd1111;
      6'd59: v = 17'd1092;
      6'd60: v = 17'd1074;
      6'd61: v = 17'd1057;
      6'd62: v = 17'd1040;
      6'd63: v = 17'd1024;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  wsg_pkg::issue_t          a_ctl;
  logic [32:0]              prod;
  logic                     p_valid;
  logic                     p_first;
  logic                     p_last;
  logic                     p_neg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  term;
  logic                     fin;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q;
  logic signed [wsg_pkg::OUT_W-1:0] sat;

  always_comb begin
    term     = p_neg ? -$signed({7'b0, prod}) : $signed({7'b0, prod});
    acc_next = (p_first ? '0 : acc) + term;
    rnd      = acc + 40'sd32768;
    q        = $signed(rnd[ACC_W-1:16]);
    if (q > 24'sd262143) begin
      sat = 19'sd262143;
    end else if (q < -24'sd262144) begin
      sat = -19'sd262144;
    end else begin
      sat = q[wsg_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      p_valid <= 1'b0;
      fin     <= 1'b0;
      res     <= '0;
    end else begin
      a_ctl   <= iss;
      p_valid <= a_ctl.valid;
      p_first <= a_ctl.first;
      p_last  <= a_ctl.last;
      p_neg   <= a_ctl.neg;
      prod    <= 33'(rom_data) * 33'(recip(a_ctl.h_idx));
      if (p_valid) begin
        acc <= acc_next;
      end
      fin       <= p_valid & p_last;
      res.valid <= fin;
      res.value <= sat;
    end
  end

endmodule

>>> hw/rtl/wsg_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_sequencer: item sequencer
// Latches an item with clamped settings, steps the harmonic phase and count,
// issues one table lookup per cycle, and resolves square mode directly.
// ----------------------------------------------------------------------------
module wsg_sequencer #(
  parameter int SINE_TABLE_BITS = wsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [wsg_pkg::FRAME_W-1:0]    frame_index,
  input  logic [wsg_pkg::SAMPLE_W-1:0]   sample_index,
  input  logic [wsg_pkg::MODE_W-1:0]     mode,
  input  logic [wsg_pkg::COUNT_W-1:0]    frame_count,
  input  logic [wsg_pkg::LOG2_W-1:0]     frame_size_log2,
  output wsg_pkg::issue_t                iss,
  output logic [SINE_TABLE_BITS-2:0]     rom_addr,
  output wsg_pkg::result_t               sq_res
);

  localparam int STB     = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (STB - 2);
  localparam int AW      = STB - 1;
  localparam int PW      = wsg_pkg::SAMPLE_W;
  localparam int CW      = wsg_pkg::COUNT_W;
  localparam int WIDE_W  = PW + STB;
  localparam int SH_W    = 5;
  localparam int HW      = wsg_pkg::HARM_W + 1;
  localparam int LIM_W   = CW + wsg_pkg::HARM_W + 1;
  localparam int SQ_W    = 28;
  localparam logic [CW-1:0] FRAMES_MAX = CW'(wsg_pkg::MAX_FRAMES);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_SQUARE} state_t;

  state_t                       state;
  logic                         saw;
  logic                         in_range;
  logic [wsg_pkg::FRAME_W-1:0]  f_r;
  logic [CW-1:0]                frames_r;
  logic [wsg_pkg::LOG2_W-1:0]   lg_r;
  logic [PW-1:0]                i_r;
  logic [PW-1:0]                mask_r;
  logic [PW-1:0]                phase;
  logic [HW-1:0]                h;
  logic [LIM_W-1:0]             hf;
  logic [LIM_W-1:0]             limit_r;

  logic [CW-1:0]                frames_cl;
  logic [wsg_pkg::LOG2_W-1:0]   lg_cl;
  logic [PW:0]                  one_sh;
  logic [PW-1:0]                mask_cl;
  logic                         in_range_cl;
  logic [CW-1:0]                diff;
  logic [LIM_W-1:0]             limit_cl;

  logic [WIDE_W-1:0]            wide;
  logic [STB-1:0]               idx;
  logic [1:0]                   quad;
  logic [AW-1:0]                addr_c;
  logic [LIM_W-1:0]             hf_next;
  logic                         cont;

  logic [20:0]                  i_f;
  logic [24:0]                  lhs;
  logic [12:0]                  f5;
  logic [12:0]                  f4;
  logic signed [12:0]           d;
  logic signed [SQ_W-1:0]       rhs;
  logic                         high;

  always_comb begin
    if (frame_count == '0) begin
      frames_cl = CW'(1);
    end else if (frame_count > FRAMES_MAX) begin
      frames_cl = FRAMES_MAX;
    end else begin
      frames_cl = frame_count;
    end
    if (frame_size_log2 < wsg_pkg::LOG2_MIN) begin
      lg_cl = wsg_pkg::LOG2_MIN;
    end else if (frame_size_log2 > wsg_pkg::LOG2_MAX) begin
      lg_cl = wsg_pkg::LOG2_MAX;
    end else begin
      lg_cl = frame_size_log2;
    end
    one_sh      = (PW + 1)'(1) << lg_cl;
    mask_cl     = PW'(one_sh - (PW + 1)'(1));
    in_range_cl = CW'(frame_index) < frames_cl;
    diff        = frames_cl - CW'(frame_index);
    limit_cl    = in_range_cl ? LIM_W'(diff * wsg_pkg::MAX_HARMONICS) : '0;

    wide = WIDE_W'(phase);
    if (lg_r <= STB) begin
      wide = wide << (SH_W'(STB) - SH_W'(lg_r));
    end else begin
      wide = wide >> (SH_W'(lg_r) - SH_W'(STB));
    end
    idx    = wide[STB-1:0];
    quad   = idx[STB-1:STB-2];
    addr_c = quad[0] ? (AW'(QUARTER) - {1'b0, idx[STB-3:0]}) : {1'b0, idx[STB-3:0]};

    hf_next = hf + LIM_W'(frames_r);
    cont    = saw && in_range && (hf_next <= limit_r);

    i_f  = 21'(i_r) * 21'(frames_r);
    lhs  = (25'(i_f) << 3) + (25'(i_f) << 1);
    f5   = 13'(frames_r) * 13'd5;
    f4   = 13'(f_r) << 2;
    d    = $signed(f5 - f4);
    rhs  = SQ_W'(d) <<< lg_r;
    high = $signed(SQ_W'(lhs)) < rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iss.valid    <= 1'b0;
      sq_res.valid <= 1'b0;
    end else begin
      iss.valid    <= 1'b0;
      sq_res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            f_r      <= frame_index;
            frames_r <= frames_cl;
            lg_r     <= lg_cl;
            mask_r   <= mask_cl;
            i_r      <= sample_index & mask_cl;
            phase    <= sample_index & mask_cl;
            h        <= HW'(1);
            hf       <= LIM_W'(frames_cl);
            limit_r  <= limit_cl;
            in_range <= in_range_cl;
            saw      <= (mode == wsg_pkg::MODE_SAW);
            state    <= (mode == wsg_pkg::MODE_SQUARE) ? S_SQUARE : S_ISSUE;
          end
        end
        S_ISSUE: begin
          iss.valid <= 1'b1;
          iss.first <= (h == HW'(1));
          iss.last  <= ~cont;
          iss.neg   <= quad[1] ^ (saw & ~h[0]);
          iss.h_idx <= wsg_pkg::HARM_W'(h - HW'(1));
          rom_addr  <= addr_c;
          if (cont) begin
            h     <= h + HW'(1);
            hf    <= hf_next;
            phase <= (phase + i_r) & mask_r;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQUARE: begin
          sq_res.valid <= 1'b1;
          sq_res.value <= high ? wsg_pkg::ONE_Q16 : -wsg_pkg::ONE_Q16;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/wavetable_sample_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_sample_generator: wavetable sample generator top level
// Configuration registers, sequencer, quarter-wave sine table, harmonic
// multiply-accumulate unit and the result register.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its sample appears on
// sample_value for exactly one cycle with done high, and busy falls in that
// same cycle, so the receiver must capture it then. In saw mode, H =
// max(1, floor(64*(frames-frame)/frames)) harmonics go one per cycle through
// the sine table and the multiply-accumulate unit; sine mode takes a single
// lookup and square mode bypasses the table. The config channel is always
// ready; the user writes it only while busy is low, which the block does not enforce.
module wavetable_sample_generator #(
  parameter int SINE_TABLE_BITS = wsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [wsg_pkg::FRAME_W-1:0]       frame_index,
  input  logic [wsg_pkg::SAMPLE_W-1:0]      sample_index,
  output logic                              done,
  output logic signed [wsg_pkg::OUT_W-1:0]  sample_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [wsg_pkg::COUNT_W-1:0] FRAMES_RST = 9'd64;
  localparam logic [wsg_pkg::LOG2_W-1:0]  LOG2_RST   = 4'd11;

  logic [wsg_pkg::MODE_W-1:0]   waveform_mode;
  logic [wsg_pkg::COUNT_W-1:0]  frame_count;
  logic [wsg_pkg::LOG2_W-1:0]   frame_size_log2;

  logic                         accept;
  wsg_pkg::issue_t              iss;
  logic [SINE_TABLE_BITS-2:0]   rom_addr;
  logic [16:0]                  rom_data;
  wsg_pkg::result_t             sq_res;
  wsg_pkg::result_t             mac_res;

  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_mode   <= '0;
      frame_count     <= FRAMES_RST;
      frame_size_log2 <= LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsg_pkg::REG_MODE:   waveform_mode   <= cfg_data[wsg_pkg::MODE_W-1:0];
        wsg_pkg::REG_FRAMES: frame_count     <= cfg_data[wsg_pkg::COUNT_W-1:0];
        wsg_pkg::REG_LOG2:   frame_size_log2 <= cfg_data[wsg_pkg::LOG2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wsg_sequencer #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .frame_index     (frame_index),
    .sample_index    (sample_index),
    .mode            (waveform_mode),
    .frame_count     (frame_count),
    .frame_size_log2 (frame_size_log2),
    .iss             (iss),
    .rom_addr        (rom_addr),
    .sq_res          (sq_res)
  );

  wsg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  wsg_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .iss      (iss),
    .rom_data (rom_data),
    .res      (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (mac_res.valid || sq_res.valid) begin
        busy <= 1'b0;
      end
      done <= mac_res.valid | sq_res.valid;
      if (sq_res.valid) begin
        sample_value <= sq_res.value;
      end else begin
        sample_value <= mac_res.value;
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the wavetable sample generator
// Drives (frame, sample) items through the start/busy handshake under several
// register settings (sine, saw, square, unused mode, out-of-range frame count
// and frame size) and checks every sample against a bit-exact predictor that
// builds its own quarter-wave sine table.
// ----------------------------------------------------------------------------
module tb;
  import wsg_pkg::*;

  localparam int ROM_BITS = SINE_TABLE_BITS_DEF;
  localparam int ROM_SIZE = 1 << ROM_BITS;
  localparam int QUARTER = ROM_SIZE / 4;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(64'sd1 <<< (OUT_W - 1));
  localparam logic [MODE_W-1:0] MODE_SINE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;

  class sample_scoreboard;
    int sine_rom[ROM_SIZE];
    logic [MODE_W-1:0] mode_reg;
    logic [COUNT_W-1:0] frames_reg;
    logic [LOG2_W-1:0] log2_reg;
    logic signed [OUT_W-1:0] pending_samples[$];
    int errors;

    function new();
      int unsigned k, quad, r;
      int v;
      for (k = 0; k < ROM_SIZE; k++) begin
        quad = k >> (ROM_BITS - 2);
        r = k & (QUARTER - 1);
        v = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
        sine_rom[k] = quad[1] ? -v : v;
      end
      mode_reg = MODE_SINE;
      frames_reg = 9'd64;
      log2_reg = 4'd11;
      errors = 0;
    endfunction

    // Q30 Taylor series up to x^13, rounded half up to Q16, capped at 1.0
    function int quarter_sine(int unsigned r);
      longint unsigned x, x2, mag;
      longint acc;
      int unsigned k;
      x = (longint'(r) * HALF_PI_Q30) / QUARTER;
      x2 = (x * x) >> 30;
      mag = x;
      acc = longint'(x);
      for (k = 1; k <= 6; k++) begin
        mag = (mag * x2) >> 30;
        mag = mag / longint'((2 * k) * (2 * k + 1));
        if (k[0]) acc = acc - longint'(mag);
        else acc = acc + longint'(mag);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 8192) >>> 14;
      if (acc > 65536) acc = 65536;
      return int'(acc);
    endfunction

    function int sine_lookup(int unsigned t, int unsigned lg);
      int unsigned idx;
      if (lg <= ROM_BITS) idx = t << (ROM_BITS - lg);
      else idx = t >> (lg - ROM_BITS);
      return sine_rom[idx & (ROM_SIZE - 1)];
    endfunction

    function int unsigned eff_frames();
      if (frames_reg < 1) return 1;
      if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
      return frames_reg;
    endfunction

    function logic signed [OUT_W-1:0] predict_sample(logic [FRAME_W-1:0] f,
                                                     logic [SAMPLE_W-1:0] si);
      int unsigned lg, frames, n, i, harm, h, t;
      longint acc, res, s, r, lhs, rhs;
      lg = log2_reg;
      if (lg < LOG2_MIN) lg = LOG2_MIN;
      if (lg > LOG2_MAX) lg = LOG2_MAX;
      frames = eff_frames();
      n = 1 << lg;
      i = si & (n - 1);
      if (mode_reg == MODE_SAW) begin
        acc = 0;
        harm = 1;
        if (f < frames) begin
          harm = (MAX_HARMONICS * (frames - f)) / frames;
          if (harm < 1) harm = 1;
        end
        for (h = 1; h <= harm; h++) begin
          t = (i * h) & (n - 1);
          s = sine_lookup(t, lg);
          r = (65536 + h / 2) / h;
          if (h[0]) acc = acc + s * r;
          else acc = acc - s * r;
        end
        res = (acc + 32768) >>> 16;
      end else if (mode_reg == MODE_SQUARE) begin
        lhs = 10 * longint'(i) * longint'(frames);
        rhs = longint'(n) * (5 * longint'(frames) - 4 * longint'(f));
        res = (lhs < rhs) ? 65536 : -65536;
      end else begin
        res = sine_lookup(i, lg);
      end
      if (res > OUT_HI) res = OUT_HI;
      if (res < OUT_LO) res = OUT_LO;
      return res[OUT_W-1:0];
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE: mode_reg = data[MODE_W-1:0];
        REG_FRAMES: frames_reg = data[COUNT_W-1:0];
        REG_LOG2: log2_reg = data[LOG2_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [FRAME_W-1:0] f, logic [SAMPLE_W-1:0] si);
      pending_samples = {pending_samples, predict_sample(f, si)};
    endfunction

    task check_sample(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (pending_samples.size() == 0) begin
        report($sformatf("sample %0d with no item outstanding", got));
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) report($sformatf("sample_value %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FRAME_W-1:0] frame_index = '0;
  logic [SAMPLE_W-1:0] sample_index = '0;
  logic done;
  logic signed [OUT_W-1:0] sample_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sample_scoreboard sb;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  wavetable_sample_generator uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .frame_index(frame_index),
    .sample_index(sample_index),
    .done(done),
    .sample_value(sample_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_sample(sample_value);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task send_item(logic [FRAME_W-1:0] f, logic [SAMPLE_W-1:0] si);
    start <= 1'b1;
    frame_index <= f;
    sample_index <= si;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(f, si);
  endtask

  task pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait out all outstanding items; registers are only written after this
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_regs(logic [MODE_W-1:0] m, logic [COUNT_W-1:0] frames, logic [LOG2_W-1:0] lg);
    logic [CFG_DATA_W-1:0] pad;
    drain();
    pad = CFG_DATA_W'($urandom);
    write_cfg(REG_MODE, {pad[CFG_DATA_W-1:MODE_W], m});
    write_cfg(REG_FRAMES, frames);
    pad = CFG_DATA_W'($urandom);
    write_cfg(REG_LOG2, {pad[CFG_DATA_W-1:LOG2_W], lg});
  endtask

  task random_items(int total);
    int sent, burst, b;
    logic [FRAME_W-1:0] f;
    logic [SAMPLE_W-1:0] si;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 12);
      for (b = 0; b < burst && sent < total; b++) begin
        if ($urandom_range(0, 9) < 8) f = FRAME_W'($urandom_range(0, sb.eff_frames() - 1));
        else f = FRAME_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0: si = '0;
          1: si = '1;
          default: si = SAMPLE_W'($urandom_range(0, 4095));
        endcase
        send_item(f, si);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
    end
  endtask

  initial begin
    int phase;
    logic [MODE_W-1:0] m;
    logic [COUNT_W-1:0] frames;
    logic [LOG2_W-1:0] lg;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: sine, 64 frames, 2048 samples
    send_item(8'd0, 12'd0);
    send_item(8'd255, 12'd4095);
    send_item(8'd3, 12'd512);
    pause(3);
    send_item(8'd7, 12'd1536);

    // saw: full harmonics, fewest, and frames at or past the count
    set_regs(MODE_SAW, 9'd64, 4'd11);
    send_item(8'd0, 12'd37);
    send_item(8'd63, 12'd300);
    send_item(8'd64, 12'd100);
    send_item(8'd255, 12'd2047);

    // square: pulse edge at i = 1024 for frame 0, always low once 4f >= 5F
    set_regs(MODE_SQUARE, 9'd64, 4'd11);
    send_item(8'd0, 12'd1023);
    send_item(8'd0, 12'd1024);
    send_item(8'd80, 12'd0);
    send_item(8'd255, 12'd0);

    set_regs(MODE_UNUSED, 9'd64, 4'd12);
    send_item(8'd5, 12'd1024);
    send_item(8'd5, 12'd4095);

    // frame count 0 and log2 below range
    set_regs(MODE_SAW, 9'd0, 4'd0);
    send_item(8'd0, 12'd4095);
    send_item(8'd1, 12'd5);

    // frame count and log2 above range, plus the unused register index
    set_regs(MODE_SQUARE, 9'd511, 4'd15);
    write_cfg(REG_UNUSED, 9'h1FF);
    send_item(8'd255, 12'd4095);
    send_item(8'd0, 12'd2047);
    send_item(8'd204, 12'd2048);

    for (phase = 0; phase < 13; phase++) begin
      case (phase)
        0: begin m = MODE_SAW; frames = 9'd256; lg = 4'd12; end
        1: begin m = MODE_SQUARE; frames = 9'd1; lg = 4'd4; end
        2: begin m = MODE_SAW; frames = 9'd511; lg = 4'd15; end
        3: begin m = MODE_SINE; frames = 9'd0; lg = 4'd0; end
        4: begin m = MODE_SAW; frames = 9'd1; lg = 4'd4; end
        default: begin
          m = MODE_W'($urandom_range(0, 3));
          frames = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(257, 511))
                                               : COUNT_W'($urandom_range(0, 256));
          lg = LOG2_W'($urandom_range(0, 15));
        end
      endcase
      set_regs(m, frames, lg);
      random_items(50);
    end

    drain();
    repeat (80) @(posedge clk);
    while (sb.pending_samples.size() != 0) begin
      sb.report("sample never produced");
      void'(sb.pending_samples.pop_front());
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/wsg_pkg.sv
hw/rtl/wsg_sine_rom.sv
hw/rtl/wsg_mac.sv
hw/rtl/wsg_sequencer.sv
hw/rtl/wavetable_sample_generator.sv
dv/tb.sv
